/* rtl/dltq_pkg.sv */
package dltq_pkg;

    localparam int DEPTH    = 16;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int HANDLE_W = 16;
    localparam int TIME_W   = 32;

    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int IN_W     = 56;
    localparam int OUT_W    = 72;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WALK_RD,
        ST_WALK_CMP,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_INS_WR,
        ST_TICK_RD,
        ST_TICK_WR,
        ST_REM_RD0,
        ST_REM_GET,
        ST_REM_RD,
        ST_REM_WR,
        ST_HEAD_RD,
        ST_HEAD_GET
    } state_t;

    // results of the shared add/compare unit
    typedef struct packed {
        logic [TIME_W-1:0] sum;      // before + delta
        logic              gt;       // sum > wait
        logic [TIME_W-1:0] diff;     // sum - wait
        logic [TIME_W-1:0] ins_dlt;  // wait - before
        logic [TIME_W-1:0] dec;      // delta - 1, held at zero
    } step_res_t;

endpackage

/* rtl/delta_list_timer_queue.sv */
// Timer queue held as a delta list in a single-port-write, registered-read store.
// Insert walks the list and moves later entries up; tick decrements the head delta;
// remove takes the head and moves the rest down; others and refusals only read the head.
// A result waits while m_tready holds the previous one. One item at a time: the next is
// taken once the result is registered.
// Reset clears the sequencer, the entry count and the output valid; the entry store
// is not cleared and needs no clearing pass, as the count bounds every read that is used.
module delta_list_timer_queue (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [1:0] cmd, [17:2] handle, [49:18] wait_time, [55:50] zero
    input  logic [dltq_pkg::IN_W-1:0]     s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [1:0] status, [2] head_valid, [18:3] head_handle, [50:19] head_wait,
    // [66:51] removed_handle, [71:67] entry_count
    output logic [dltq_pkg::OUT_W-1:0]    m_tdata
);

    localparam int AW = dltq_pkg::ADDR_W;
    localparam int CW = dltq_pkg::CNT_W;
    localparam int HW = dltq_pkg::HANDLE_W;
    localparam int TW = dltq_pkg::TIME_W;

    // entry store
    logic [HW-1:0] hnd_mem [dltq_pkg::DEPTH];
    logic [TW-1:0] dlt_mem [dltq_pkg::DEPTH];

    dltq_pkg::state_t state_reg, state_next;

    logic [dltq_pkg::CMD_W-1:0]    cmd_reg, cmd_next;
    logic [HW-1:0]                 hnd_in_reg, hnd_in_next;
    logic [TW-1:0]                 wt_reg, wt_next;
    logic [CW-1:0]                 count_reg, count_next;
    logic [CW-1:0]                 idx_reg, idx_next;
    logic [AW-1:0]                 pos_reg, pos_next;
    logic [TW-1:0]                 before_reg, before_next;
    logic [TW-1:0]                 adj_reg, adj_next;
    logic [dltq_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [HW-1:0]                 removed_reg, removed_next;
    logic                          m_valid_reg, m_valid_next;
    logic [dltq_pkg::OUT_W-1:0]    m_data_reg, m_data_next;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [HW-1:0] rd_hnd_reg;
    logic [TW-1:0] rd_dlt_reg;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [HW-1:0] wr_hnd;
    logic [TW-1:0] wr_dlt;

    logic                in_acc;
    logic                out_free;
    logic [CW-1:0]       idx_inc, idx_dec;
    logic                head_ok;
    dltq_pkg::step_res_t su;

    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign idx_inc  = idx_reg + CW'(1);
    assign idx_dec  = idx_reg - CW'(1);
    assign head_ok  = (count_reg != '0);

    assign s_tready = (state_reg == dltq_pkg::ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    dltq_step_unit u_step (
        .prior     (before_reg),
        .delta     (rd_dlt_reg),
        .wait_time (wt_reg),
        .res       (su)
    );

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            hnd_mem[wr_addr] <= wr_hnd;
            dlt_mem[wr_addr] <= wr_dlt;
        end
        if (rd_en) begin
            rd_hnd_reg <= hnd_mem[rd_addr];
            rd_dlt_reg <= dlt_mem[rd_addr];
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            dltq_pkg::ST_IDLE: begin
                if (in_acc) begin
                    unique case (s_tdata[1:0])
                        dltq_pkg::CMD_INSERT: begin
                            if (count_reg == CW'(dltq_pkg::DEPTH)) begin
                                state_next = dltq_pkg::ST_HEAD_RD;
                            end else if (!head_ok) begin
                                state_next = dltq_pkg::ST_INS_WR;
                            end else begin
                                state_next = dltq_pkg::ST_WALK_RD;
                            end
                        end
                        dltq_pkg::CMD_TICK: begin
                            state_next = head_ok ? dltq_pkg::ST_TICK_RD : dltq_pkg::ST_HEAD_RD;
                        end
                        dltq_pkg::CMD_REMOVE: begin
                            state_next = head_ok ? dltq_pkg::ST_REM_RD0 : dltq_pkg::ST_HEAD_RD;
                        end
                        default: state_next = dltq_pkg::ST_HEAD_RD;
                    endcase
                end
            end
            dltq_pkg::ST_WALK_RD:  state_next = dltq_pkg::ST_WALK_CMP;
            dltq_pkg::ST_WALK_CMP: begin
                if (su.gt) begin
                    state_next = dltq_pkg::ST_SHIFT_RD;
                end else if (idx_inc == count_reg) begin
                    state_next = dltq_pkg::ST_INS_WR;
                end else begin
                    state_next = dltq_pkg::ST_WALK_RD;
                end
            end
            dltq_pkg::ST_SHIFT_RD: state_next = dltq_pkg::ST_SHIFT_WR;
            dltq_pkg::ST_SHIFT_WR: begin
                state_next = (idx_dec == CW'(pos_reg)) ? dltq_pkg::ST_INS_WR
                                                        : dltq_pkg::ST_SHIFT_RD;
            end
            dltq_pkg::ST_INS_WR:   state_next = dltq_pkg::ST_HEAD_RD;
            dltq_pkg::ST_TICK_RD:  state_next = dltq_pkg::ST_TICK_WR;
            dltq_pkg::ST_TICK_WR:  state_next = dltq_pkg::ST_HEAD_RD;
            dltq_pkg::ST_REM_RD0:  state_next = dltq_pkg::ST_REM_GET;
            dltq_pkg::ST_REM_GET: begin
                state_next = (count_reg == CW'(1)) ? dltq_pkg::ST_HEAD_RD
                                                    : dltq_pkg::ST_REM_RD;
            end
            dltq_pkg::ST_REM_RD:   state_next = dltq_pkg::ST_REM_WR;
            dltq_pkg::ST_REM_WR: begin
                state_next = (idx_inc == count_reg) ? dltq_pkg::ST_HEAD_RD
                                                     : dltq_pkg::ST_REM_RD;
            end
            dltq_pkg::ST_HEAD_RD:  state_next = dltq_pkg::ST_HEAD_GET;
            dltq_pkg::ST_HEAD_GET: begin
                if (out_free) begin
                    state_next = dltq_pkg::ST_IDLE;
                end
            end
            default: state_next = dltq_pkg::ST_IDLE;
        endcase
    end

    // datapath and store control
    always_comb begin
        cmd_next     = cmd_reg;
        hnd_in_next  = hnd_in_reg;
        wt_next      = wt_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        pos_next     = pos_reg;
        before_next  = before_reg;
        adj_next     = adj_reg;
        status_next  = status_reg;
        removed_next = removed_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        rd_en        = 1'b0;
        rd_addr      = '0;
        wr_en        = 1'b0;
        wr_addr      = '0;
        wr_hnd       = rd_hnd_reg;
        wr_dlt       = rd_dlt_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            dltq_pkg::ST_IDLE: begin
                if (in_acc) begin
                    cmd_next     = s_tdata[1:0];
                    hnd_in_next  = s_tdata[17:2];
                    wt_next      = s_tdata[49:18];
                    idx_next     = '0;
                    pos_next     = '0;
                    before_next  = '0;
                    removed_next = '0;
                    status_next  = dltq_pkg::STAT_OK;
                    if (s_tdata[1:0] == dltq_pkg::CMD_INSERT
                            && count_reg == CW'(dltq_pkg::DEPTH)) begin
                        status_next = dltq_pkg::STAT_FULL;
                    end
                    if ((s_tdata[1:0] == dltq_pkg::CMD_TICK
                            || s_tdata[1:0] == dltq_pkg::CMD_REMOVE) && !head_ok) begin
                        status_next = dltq_pkg::STAT_EMPTY;
                    end
                end
            end
            dltq_pkg::ST_WALK_RD: begin
                rd_en   = 1'b1;
                rd_addr = idx_reg[AW-1:0];
            end
            dltq_pkg::ST_WALK_CMP: begin
                if (su.gt) begin
                    pos_next = idx_reg[AW-1:0];
                    adj_next = su.diff;
                    idx_next = count_reg;
                end else begin
                    before_next = su.sum;
                    idx_next    = idx_inc;
                    pos_next    = idx_inc[AW-1:0];
                end
            end
            dltq_pkg::ST_SHIFT_RD: begin
                rd_en   = 1'b1;
                rd_addr = idx_dec[AW-1:0];
            end
            dltq_pkg::ST_SHIFT_WR: begin
                wr_en    = 1'b1;
                wr_addr  = idx_reg[AW-1:0];
                // the entry that now follows the new one keeps its absolute wait
                if (idx_dec == CW'(pos_reg)) begin
                    wr_dlt = adj_reg;
                end
                idx_next = idx_dec;
            end
            dltq_pkg::ST_INS_WR: begin
                wr_en      = 1'b1;
                wr_addr    = pos_reg;
                wr_hnd     = hnd_in_reg;
                wr_dlt     = su.ins_dlt;
                count_next = count_reg + CW'(1);
            end
            dltq_pkg::ST_TICK_RD: begin
                rd_en = 1'b1;
            end
            dltq_pkg::ST_TICK_WR: begin
                wr_en  = 1'b1;
                wr_dlt = su.dec;
            end
            dltq_pkg::ST_REM_RD0: begin
                rd_en = 1'b1;
            end
            dltq_pkg::ST_REM_GET: begin
                removed_next = rd_hnd_reg;
                idx_next     = CW'(1);
                if (count_reg == CW'(1)) begin
                    count_next = '0;
                end
            end
            dltq_pkg::ST_REM_RD: begin
                rd_en   = 1'b1;
                rd_addr = idx_reg[AW-1:0];
            end
            dltq_pkg::ST_REM_WR: begin
                wr_en    = 1'b1;
                wr_addr  = idx_dec[AW-1:0];
                idx_next = idx_inc;
                if (idx_inc == count_reg) begin
                    count_next = count_reg - CW'(1);
                end
            end
            dltq_pkg::ST_HEAD_RD: begin
                rd_en = 1'b1;
            end
            dltq_pkg::ST_HEAD_GET: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {count_reg,
                                    removed_reg,
                                    head_ok ? rd_dlt_reg : TW'(0),
                                    head_ok ? rd_hnd_reg : HW'(0),
                                    head_ok,
                                    status_reg};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= dltq_pkg::ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        hnd_in_reg  <= hnd_in_next;
        wt_reg      <= wt_next;
        idx_reg     <= idx_next;
        pos_reg     <= pos_next;
        before_reg  <= before_next;
        adj_reg     <= adj_next;
        status_reg  <= status_next;
        removed_reg <= removed_next;
        m_data_reg  <= m_data_next;
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(dltq_pkg::DEPTH))
        else $error("entry count beyond depth");

    a_count_change: assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(count_reg) |-> ($past(state_reg) == dltq_pkg::ST_INS_WR
                                 || $past(state_reg) == dltq_pkg::ST_REM_GET
                                 || $past(state_reg) == dltq_pkg::ST_REM_WR))
        else $error("entry count moved outside insert or remove");

    a_empty_head: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg[71:67] == '0) |-> (m_data_reg[50:2] == '0))
        else $error("empty queue reports a head entry");

    a_busy_no_take: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == dltq_pkg::ST_HEAD_GET && !out_free) |=> state_reg == dltq_pkg::ST_HEAD_GET)
        else $error("result slot overwritten");

endmodule

/* rtl/dltq_step_unit.sv */
module dltq_step_unit (
    input  logic [dltq_pkg::TIME_W-1:0] prior,
    input  logic [dltq_pkg::TIME_W-1:0] delta,
    input  logic [dltq_pkg::TIME_W-1:0] wait_time,
    output dltq_pkg::step_res_t         res
);

    logic [dltq_pkg::TIME_W-1:0] sum;

    assign sum         = prior + delta;
    assign res.sum     = sum;
    assign res.gt      = (sum > wait_time);
    assign res.diff    = sum - wait_time;
    assign res.ins_dlt = wait_time - prior;
    assign res.dec     = (delta == '0) ? delta : delta - dltq_pkg::TIME_W'(1);

endmodule
